FILE: rtl/core/sha1mh_pkg.sv
package sha1mh_pkg;

    typedef logic [31:0] word_t;

    // Chaining value, entry 0 is h0
    typedef logic [4:0][31:0] chain_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
    } work_vars_t;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_idx;
        logic [7:0] wr_byte;
        logic       shift;
    } sched_ctrl_t;

    localparam chain_t SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam word_t K_CH  = 32'h5A827999;
    localparam word_t K_PA0 = 32'h6ED9EBA1;
    localparam word_t K_MAJ = 32'h8F1BBCDC;
    localparam word_t K_PA1 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    localparam logic [1:0] OP_ABSORB     = 2'd0;
    localparam logic [1:0] OP_ABSORB_FIN = 2'd1;
    localparam logic [1:0] OP_FINISH     = 2'd2;

endpackage

FILE: rtl/core/sha1mh_round.sv
module sha1mh_round (
    input  logic [6:0]              rnd,
    input  sha1mh_pkg::work_vars_t  cur,
    input  sha1mh_pkg::word_t       w,
    output sha1mh_pkg::work_vars_t  nxt
);
    import sha1mh_pkg::*;

    word_t f;
    word_t k;
    word_t t;

    always_comb
    begin
        if (rnd < 7'd20)
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K_CH;
        end
        else if (rnd < 7'd40)
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_PA0;
        end
        else if (rnd < 7'd60)
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K_MAJ;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_PA1;
        end
        t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

        nxt.a = t;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

FILE: rtl/core/sha1mh_sched.sv
module sha1mh_sched (
    input  logic                     clk,
    input  sha1mh_pkg::sched_ctrl_t  ctrl,
    output sha1mh_pkg::word_t        w
);
    import sha1mh_pkg::*;

    // Block buffer and expansion window in one: bytes land here, rounds shift it
    word_t win_reg [16];
    word_t w_new;

    assign w   = win_reg[0];
    assign w_new = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= {w_new[30:0], w_new[31]};
        end
        else if (ctrl.wr_en)
        begin
            // big-endian: byte 0 of a word goes to bits 31:24
            win_reg[ctrl.wr_idx[5:2]][{~ctrl.wr_idx[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
        end
    end

endmodule

FILE: rtl/core/sha1_message_hasher.sv
// Channel   Ports                                         Handshake
// request   opcode, msg_byte                              start && !busy
// digest    digest_word, word_index, last_word            digest_valid per word
//
// An absorbed byte is written straight into the block; the 64th byte of a block also starts
// a compression (one load, 80 rounds through the single round unit, one chaining add).
// A finish writes padding one byte per cycle to the end of its last block, compresses
// one or two blocks, then sends five digest words back to back.
// busy drops as the fifth word goes out; the digest receiver cannot stall.
// rst_n clears the control state and reloads the initial chaining value.
module sha1_message_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  msg_byte,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1mh_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        fin_reg, fin_next;
    logic        mark_reg, mark_next;
    logic        final_reg, final_next;
    logic [2:0]  idx_reg, idx_next;
    chain_t      h_reg, h_next;
    work_vars_t  wv_reg, wv_next;
    logic        valid_reg, valid_next;
    word_t       dword_reg, dword_next;
    logic [2:0]  windex_reg, windex_next;
    logic        wlast_reg, wlast_next;

    sched_ctrl_t sctrl;
    word_t       w_cur;
    work_vars_t  wv_round;
    logic [7:0]  tail_byte;

    sha1mh_sched u_sched (
        .clk  (clk),
        .ctrl (sctrl),
        .w    (w_cur)
    );

    sha1mh_round u_round (
        .rnd (rnd_reg),
        .cur (wv_reg),
        .w   (w_cur),
        .nxt (wv_round)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign digest_valid = valid_reg;
    assign digest_word  = dword_reg;
    assign word_index   = windex_reg;
    assign last_word    = wlast_reg;

    // Length bytes go out most significant first in bytes 56..63
    always_comb
    begin
        if (mark_reg)
        begin
            tail_byte = PAD_MARK;
        end
        else if (final_reg && (fill_reg[5:3] == 3'b111))
        begin
            tail_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            tail_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        fin_next    = fin_reg;
        mark_next   = mark_reg;
        final_next  = final_reg;
        idx_next    = idx_reg;
        h_next      = h_reg;
        wv_next     = wv_reg;
        valid_next  = 1'b0;
        dword_next  = dword_reg;
        windex_next = windex_reg;
        wlast_next  = wlast_reg;
        sctrl       = '{wr_en: 1'b0, wr_idx: fill_reg, wr_byte: msg_byte, shift: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    final_next = 1'b0;
                    if (opcode == OP_ABSORB || opcode == OP_ABSORB_FIN)
                    begin
                        sctrl.wr_en = 1'b1;
                        fill_next   = fill_reg + 6'd1;
                        bits_next   = bits_reg + 64'd8;
                        fin_next    = (opcode == OP_ABSORB_FIN);
                        mark_next   = (opcode == OP_ABSORB_FIN);
                        if (fill_reg == FILL_LAST)
                        begin
                            state_next = ST_LOAD;
                        end
                        else if (opcode == OP_ABSORB_FIN)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (opcode == OP_FINISH)
                    begin
                        fin_next   = 1'b1;
                        mark_next  = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                sctrl.wr_en   = 1'b1;
                sctrl.wr_byte = tail_byte;
                fill_next     = fill_reg + 6'd1;
                if (mark_reg)
                begin
                    mark_next  = 1'b0;
                    // length fits after the mark only if the mark lands below byte 56
                    final_next = (fill_reg < LEN_START);
                end
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                wv_next    = '{a: h_reg[0], b: h_reg[1], c: h_reg[2],
                               d: h_reg[3], e: h_reg[4]};
                rnd_next   = 7'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                sctrl.shift = 1'b1;
                wv_next     = wv_round;
                rnd_next    = rnd_reg + 7'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                h_next[0] = h_reg[0] + wv_reg.a;
                h_next[1] = h_reg[1] + wv_reg.b;
                h_next[2] = h_reg[2] + wv_reg.c;
                h_next[3] = h_reg[3] + wv_reg.d;
                h_next[4] = h_reg[4] + wv_reg.e;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (final_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // the next block carries the length, after the mark if it is still pending
                    if (!mark_reg)
                    begin
                        final_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                valid_next  = 1'b1;
                dword_next  = h_reg[idx_reg];
                windex_next = idx_reg;
                wlast_next  = (idx_reg == WORD_LAST);
                idx_next    = idx_reg + 3'd1;
                if (idx_reg == WORD_LAST)
                begin
                    h_next     = SHA1_IV;
                    fill_next  = 6'd0;
                    bits_next  = 64'd0;
                    fin_next   = 1'b0;
                    final_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 7'd0;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= 3'd0;
            h_reg     <= SHA1_IV;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg     <= wv_next;
        dword_reg  <= dword_next;
        windex_reg <= windex_next;
        wlast_reg  <= wlast_next;
    end

`ifndef SYNTHESIS
    a_last_is_fifth: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && last_word |-> word_index == WORD_LAST)
        else $error("last digest word not at index four");

    a_words_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !last_word |=> digest_valid && word_index == $past(word_index) + 3'd1)
        else $error("digest words not consecutive");

    a_finish_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_FINISH |=> busy && fin_reg)
        else $error("finish request did not start padding");

    a_emit_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> fill_reg == 6'd0 && !mark_reg)
        else $error("digest sent with partial block pending");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> rnd_reg <= ROUND_LAST)
        else $error("round counter out of range");
`endif

endmodule

FILE: sim/tb_sha1_message_hasher.sv
module tb_sha1_message_hasher;

    import sha1mh_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned REQUEST_TARGET = 170;

    localparam logic [159:0] DIGEST_EMPTY =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DIGEST_ABC =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_out_t;

    typedef struct packed {
        logic [1:0]   op;
        logic [7:0]   data;
        logic         known;
        logic [159:0] digest;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  opcode = OP_ABSORB;
    logic [7:0]  msg_byte = 8'h00;
    logic        busy;
    logic        digest_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Predicted hasher state
    logic [31:0] chain_h [5];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [63:0] msg_len_bits;

    digest_out_t pending_words [$];
    plan_row_t   plan [14];

    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned requests_counted = 0;
    int unsigned requests_ignored = 0;
    int unsigned messages_hashed = 0;
    int unsigned burst_left = 1;

    sha1_message_hasher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .msg_byte     (msg_byte),
        .digest_valid (digest_valid),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    always #1 clk = ~clk;

    function automatic void hash_restart();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        blk_fill = 0;
        msg_len_bits = 64'd0;
    endfunction

    function automatic void hash_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, nw;
        int s;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            s = r & 15;
            if (r >= 16)
            begin
                nw = w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s];
                w[s] = {nw[30:0], nw[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[s];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endfunction

    function automatic void hash_absorb(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill = blk_fill + 1;
        msg_len_bits = msg_len_bits + 64'd8;
        if (blk_fill == 64)
        begin
            hash_compress();
            blk_fill = 0;
        end
    endfunction

    function automatic logic [159:0] hash_finish();
        logic [63:0]  total;
        logic [159:0] dg;
        total = msg_len_bits;
        blk_bytes[blk_fill] = 8'h80;
        blk_fill = blk_fill + 1;
        // No room for the length: close this block and pad a second one
        if (blk_fill > 56)
        begin
            while (blk_fill < 64)
            begin
                blk_bytes[blk_fill] = 8'h00;
                blk_fill = blk_fill + 1;
            end
            hash_compress();
            blk_fill = 0;
        end
        while (blk_fill < 56)
        begin
            blk_bytes[blk_fill] = 8'h00;
            blk_fill = blk_fill + 1;
        end
        for (int i = 0; i < 8; i++)
        begin
            blk_bytes[56 + i] = total[63 - 8*i -: 8];
        end
        hash_compress();
        dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        hash_restart();
        return dg;
    endfunction

    function automatic void queue_digest(input logic [159:0] dg);
        digest_out_t item;
        for (int i = 0; i < 5; i++)
        begin
            item.word = dg[159 - 32*i -: 32];
            item.idx  = 3'(i);
            item.last = (i == 4);
            pending_words.push_back(item);
        end
        messages_hashed++;
    endfunction

    // Advance the predictor by one accepted request
    function automatic void apply_request(input logic [1:0] op, input logic [7:0] b,
                                          input logic known, input logic [159:0] typed);
        logic [159:0] dg;
        dg = '0;
        case (op)
            OP_ABSORB:
            begin
                hash_absorb(b);
                requests_counted++;
                return;
            end
            OP_ABSORB_FIN:
            begin
                hash_absorb(b);
                dg = hash_finish();
            end
            OP_FINISH:
            begin
                dg = hash_finish();
            end
            default:
            begin
                requests_ignored++;
                return;
            end
        endcase
        requests_counted++;
        queue_digest(known ? typed : dg);
    endfunction

    task automatic idle_gap(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold the request until the block takes it, then pace the next one
    task automatic send_request(input logic [1:0] op, input logic [7:0] b,
                                input logic known = 1'b0,
                                input logic [159:0] typed = '0);
        start    <= 1'b1;
        opcode   <= op;
        msg_byte <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_request(op, b, known, typed);
        burst_left--;
        if (burst_left == 0)
        begin
            idle_gap($urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain_digests();
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
    endtask

    task automatic send_message(input int unsigned len);
        logic finish_with_byte;
        finish_with_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(OP_UNUSED, 8'($urandom_range(0, 255)));
            if (finish_with_byte && i == len - 1)
                send_request(OP_ABSORB_FIN, 8'($urandom_range(0, 255)));
            else
                send_request(OP_ABSORB, 8'($urandom_range(0, 255)));
        end
        if (!finish_with_byte)
            send_request(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        digest_out_t want;
        if (rst_n && digest_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $error("digest word %h with no digest pending", digest_word);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (digest_word !== want.word)
                begin
                    $error("digest_word: expected %h, got %h", want.word, digest_word);
                    mismatches++;
                end
                if (word_index !== want.idx)
                begin
                    $error("word_index: expected %0d, got %0d", want.idx, word_index);
                    mismatches++;
                end
                if (last_word !== want.last)
                begin
                    $error("last_word: expected %0b, got %0b", want.last, last_word);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int unsigned len;
        hash_restart();
        plan = '{
            '{OP_FINISH,     8'h00, 1'b1, DIGEST_EMPTY},
            '{OP_FINISH,     8'h5A, 1'b1, DIGEST_EMPTY},
            '{OP_UNUSED,     8'hFF, 1'b0, 160'd0},
            '{OP_ABSORB,     8'h61, 1'b0, 160'd0},
            '{OP_UNUSED,     8'h00, 1'b0, 160'd0},
            '{OP_ABSORB,     8'h62, 1'b0, 160'd0},
            '{OP_ABSORB_FIN, 8'h63, 1'b1, DIGEST_ABC},
            '{OP_FINISH,     8'h00, 1'b1, DIGEST_EMPTY},
            '{OP_ABSORB,     8'h00, 1'b0, 160'd0},
            '{OP_ABSORB,     8'hFF, 1'b0, 160'd0},
            '{OP_ABSORB_FIN, 8'hFF, 1'b0, 160'd0},
            '{OP_ABSORB_FIN, 8'h00, 1'b0, 160'd0},
            '{OP_UNUSED,     8'h55, 1'b0, 160'd0},
            '{OP_FINISH,     8'hAA, 1'b1, DIGEST_EMPTY}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = $urandom_range(1, 24);
        foreach (plan[i])
        begin
            send_request(plan[i].op, plan[i].data, plan[i].known, plan[i].digest);
        end
        drain_digests();

        // Mostly short messages, a few around the padding and block boundaries
        while (requests_counted < REQUEST_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 6))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    default: len = 119;
                endcase
            end
            else
            begin
                len = $urandom_range(0, 12);
            end
            // Trim the last message so the request count lands near the target
            if (len > REQUEST_TARGET - requests_counted)
                len = REQUEST_TARGET - requests_counted;
            send_message(len);
            if ($urandom_range(0, 9) == 0)
                drain_digests();
        end

        drain_digests();
        repeat (300) @(posedge clk);
        $display("%0d requests accepted, %0d with the unused opcode ignored",
                 requests_counted + requests_ignored, requests_ignored);
        $display("%0d messages hashed, %0d digest words checked",
                 messages_hashed, words_checked);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("timeout with %0d digest words pending", pending_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sha1mh_pkg.sv
rtl/core/sha1mh_round.sv
rtl/core/sha1mh_sched.sv
rtl/core/sha1_message_hasher.sv
sim/tb_sha1_message_hasher.sv
